@@ design/vrrq_pkg.sv @@
// Shared constants, codes and types for the variable record ring queue.
`timescale 1ns / 1ps

package vrrq_pkg;

   // Ring size in bytes; a power of two so that positions wrap by truncation.
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int SUM_W    = CNT_W + 1;

   localparam int OP_W   = 3;
   localparam int BYTE_W = 8;

   localparam logic [OP_W-1:0] OP_RESERVE = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE   = 3'd1;
   localparam logic [OP_W-1:0] OP_POP     = 3'd2;
   localparam logic [OP_W-1:0] OP_READ    = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   typedef struct packed {
      logic              byte_we;
      addr_type          byte_waddr;
      logic [BYTE_W-1:0] byte_wdata;
      logic              byte_re;
      addr_type          byte_raddr;
      logic              len_we;
      addr_type          len_waddr;
      cnt_type           len_wdata;
      logic              len_re;
      addr_type          len_raddr;
   } mem_cmd_type;

   typedef struct packed {
      logic ok;
      logic rd_ok;
   } op_result_type;

   typedef struct packed {
      cnt_type head_length;
      cnt_type bytes_used;
      cnt_type bytes_free;
      cnt_type record_count;
   } ring_stat_type;

endpackage

@@ design/vrrq_ptr.sv @@
// Ring pointer state, request decode and store access generation.
`timescale 1ns / 1ps

module vrrq_ptr
   import vrrq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [OP_W-1:0]   operation,
   input  logic [BYTE_W-1:0] data_byte,
   input  cnt_type           record_length,
   input  addr_type          byte_offset,
   input  cnt_type           len_rd_data,
   output mem_cmd_type       mem_cmd,
   output op_result_type     op_res,
   output ring_stat_type     ring_stat
);

   addr_type head_ff, head_in;
   addr_type tail_ff, tail_in;
   cnt_type  gap_ff, gap_in;
   logic     last_push_ff, last_push_in;
   cnt_type  records_ff, records_in;
   addr_type write_pos_ff, write_pos_in;
   cnt_type  write_left_ff, write_left_in;
   cnt_type  head_len_ff, head_len_in;
   logic     pop_pend_ff, pop_pend_in;

   cnt_type           head_len;
   cnt_type           top;
   cnt_type           free_now;
   cnt_type           used_now;
   logic [SUM_W-1:0]  tail_sum;
   logic [SUM_W-1:0]  pop_next;
   logic              place;
   addr_type          place_pos;

   // Head length: fresh from the length store just after a pop, set by a reserve into an empty ring, else held.
   assign head_len = pop_pend_ff ? len_rd_data : head_len_ff;
   assign top      = CAP_CNT - gap_ff;
   assign tail_sum = SUM_W'(tail_ff) + SUM_W'(record_length);
   assign pop_next = SUM_W'(head_ff) + SUM_W'(head_len);

   always_comb begin
      if (head_ff < tail_ff) begin
         free_now = CAP_CNT - CNT_W'(tail_ff) + CNT_W'(head_ff);
         used_now = CNT_W'(tail_ff) - CNT_W'(head_ff);
      end else if (head_ff > tail_ff) begin
         free_now = CNT_W'(head_ff) - CNT_W'(tail_ff);
         used_now = ((top >= CNT_W'(head_ff)) ? (top - CNT_W'(head_ff)) : '0)
                    + CNT_W'(tail_ff);
      end else if (last_push_ff) begin
         free_now = '0;
         used_now = ((top >= CNT_W'(head_ff)) ? (top - CNT_W'(head_ff)) : '0)
                    + CNT_W'(tail_ff);
      end else begin
         free_now = CAP_CNT;
         used_now = '0;
      end
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      gap_in        = gap_ff;
      last_push_in  = last_push_ff;
      records_in    = records_ff;
      write_pos_in  = write_pos_ff;
      write_left_in = write_left_ff;
      head_len_in   = head_len;
      pop_pend_in   = 1'b0;
      mem_cmd       = '0;
      op_res        = '0;
      place         = 1'b0;
      place_pos     = tail_ff;

      if (accept) begin
         case (operation)
            OP_RESERVE: begin
               if (record_length == '0 || record_length > CAP_CNT) begin
                  place = 1'b0;
               end else if (tail_sum > SUM_W'(CAP_CNT)) begin
                  // Record would cross the end: restart at zero if room.
                  if (records_ff == '0) begin
                     head_in   = '0;
                     gap_in    = '0;
                     place     = 1'b1;
                     place_pos = '0;
                  end else if (head_ff < tail_ff &&
                               record_length <= CNT_W'(head_ff)) begin
                     gap_in    = CAP_CNT - CNT_W'(tail_ff);
                     place     = 1'b1;
                     place_pos = '0;
                  end
               end else if (free_now >= record_length) begin
                  place = 1'b1;
               end
               if (place) begin
                  mem_cmd.len_we    = 1'b1;
                  mem_cmd.len_waddr = place_pos;
                  mem_cmd.len_wdata = record_length;
                  write_pos_in      = place_pos;
                  write_left_in     = record_length;
                  tail_in           = place_pos + ADDR_W'(record_length);
                  last_push_in      = 1'b1;
                  records_in        = records_ff + 1'b1;
                  op_res.ok         = 1'b1;
                  if (records_ff == '0) begin
                     head_len_in = record_length;
                  end
               end
            end
            OP_WRITE: begin
               if (write_left_ff != '0) begin
                  mem_cmd.byte_we    = 1'b1;
                  mem_cmd.byte_waddr = write_pos_ff;
                  mem_cmd.byte_wdata = data_byte;
                  write_pos_in       = write_pos_ff + 1'b1;
                  write_left_in      = write_left_ff - 1'b1;
                  op_res.ok          = 1'b1;
               end
            end
            OP_POP: begin
               if (records_ff != '0) begin
                  if (pop_next >= SUM_W'(top)) begin
                     head_in = ADDR_W'(pop_next - SUM_W'(top));
                     gap_in  = '0;
                  end else begin
                     head_in = ADDR_W'(pop_next);
                  end
                  last_push_in = 1'b0;
                  records_in   = records_ff - 1'b1;
                  op_res.ok    = 1'b1;
                  if (records_ff == CNT_W'(1)) begin
                     write_left_in = '0;
                  end else begin
                     // Fetch the length of the new head record.
                     mem_cmd.len_re    = 1'b1;
                     mem_cmd.len_raddr = head_in;
                     pop_pend_in       = 1'b1;
                  end
               end
            end
            OP_READ: begin
               if (records_ff != '0 && CNT_W'(byte_offset) < head_len) begin
                  mem_cmd.byte_re    = 1'b1;
                  mem_cmd.byte_raddr = head_ff + byte_offset;
                  op_res.ok          = 1'b1;
                  op_res.rd_ok       = 1'b1;
               end
            end
            OP_CLEAR: begin
               head_in       = '0;
               tail_in       = '0;
               gap_in        = '0;
               last_push_in  = 1'b0;
               records_in    = '0;
               write_pos_in  = '0;
               write_left_in = '0;
               op_res.ok     = 1'b1;
            end
            default: begin
               op_res = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         gap_ff        <= '0;
         last_push_ff  <= 1'b0;
         records_ff    <= '0;
         write_pos_ff  <= '0;
         write_left_ff <= '0;
         head_len_ff   <= '0;
         pop_pend_ff   <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         gap_ff        <= gap_in;
         last_push_ff  <= last_push_in;
         records_ff    <= records_in;
         write_pos_ff  <= write_pos_in;
         write_left_ff <= write_left_in;
         head_len_ff   <= head_len_in;
         pop_pend_ff   <= pop_pend_in;
      end
   end

   assign ring_stat.head_length  = (records_ff != '0) ? head_len : '0;
   assign ring_stat.bytes_used   = used_now;
   assign ring_stat.bytes_free   = free_now;
   assign ring_stat.record_count = records_ff;

   a_empty_aligned: assert property (@(posedge clock) disable iff (reset)
      records_ff == '0 |-> head_ff == tail_ff && !last_push_ff)
      else $error("empty ring with head and tail apart");

   a_empty_no_open: assert property (@(posedge clock) disable iff (reset)
      records_ff == '0 |-> write_left_ff == '0)
      else $error("open record write with no record held");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      records_ff <= CAP_CNT && write_left_ff <= CAP_CNT && gap_ff < CAP_CNT)
      else $error("ring counter out of range");

endmodule

@@ design/variable_record_ring_queue.sv @@
// Top level of the variable record ring queue: stores, pipeline and handshake.
`timescale 1ns / 1ps
// An accepted request passes the decode/update stage register and the response
// register before rsp_valid rises. Throughput: one request per cycle while
// responses are taken, set by one access per store per cycle.
// Reset (synchronous, active high) empties the ring and drops in-flight requests.
// The byte and length stores are not cleared; entries are undefined until written.

module variable_record_ring_queue
   import vrrq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [OP_W-1:0]   req_operation,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic [10:0]       req_record_length,
   input  logic [9:0]        req_byte_offset,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_ok,
   output logic [BYTE_W-1:0] rsp_read_data,
   output logic [10:0]       rsp_head_length,
   output logic [10:0]       rsp_bytes_used,
   output logic [10:0]       rsp_bytes_free,
   output logic [10:0]       rsp_record_count
);

   // Stores: one write and one registered read per cycle each.
   logic [BYTE_W-1:0] byte_store_ff [CAPACITY];
   cnt_type           length_store_ff [CAPACITY];
   logic [BYTE_W-1:0] byte_rd_ff;
   cnt_type           len_rd_ff;

   // Pipeline: decode/update stage, then the response register.
   logic          s1_vld_ff;
   op_result_type s1_res_ff;
   logic          rsp_valid_ff;
   logic          rsp_ok_ff;
   logic [BYTE_W-1:0] rsp_read_data_ff;
   cnt_type       rsp_head_length_ff;
   cnt_type       rsp_bytes_used_ff;
   cnt_type       rsp_bytes_free_ff;
   cnt_type       rsp_record_count_ff;

   logic          out_free;
   logic          s1_free;
   logic          accept;
   mem_cmd_type   mem_cmd;
   op_result_type op_res;
   ring_stat_type ring_stat;

   // Advance the response register when empty or taken; the stage behind
   // it moves whenever it can hand over.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_free   = !s1_vld_ff || out_free;
   assign req_stall = !s1_free;
   assign accept    = req_valid && s1_free;

   // Ring state updates on acceptance; store accesses issue in the same edge.
   vrrq_ptr u_ptr (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .operation     (req_operation),
      .data_byte     (req_data_byte),
      .record_length (CNT_W'(req_record_length)),
      .byte_offset   (ADDR_W'(req_byte_offset)),
      .len_rd_data   (len_rd_ff),
      .mem_cmd       (mem_cmd),
      .op_res        (op_res),
      .ring_stat     (ring_stat)
   );

   // Byte store: write a record byte, read a head byte.
   always_ff @(posedge clock) begin
      if (mem_cmd.byte_we) begin
         byte_store_ff[mem_cmd.byte_waddr] <= mem_cmd.byte_wdata;
      end
      if (mem_cmd.byte_re) begin
         byte_rd_ff <= byte_store_ff[mem_cmd.byte_raddr];
      end
   end

   // Length store: write on reserve, read the new head length on a pop that
   // leaves a record. The read data holds until the next such pop; the pointer
   // logic takes it as the head length right after the pop and keeps a copy.
   always_ff @(posedge clock) begin
      if (mem_cmd.len_we) begin
         length_store_ff[mem_cmd.len_waddr] <= mem_cmd.len_wdata;
      end
      if (mem_cmd.len_re) begin
         len_rd_ff <= length_store_ff[mem_cmd.len_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_vld_ff <= accept;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_vld_ff;
         end
      end
   end

   // Hold the per-request outcome until the response register takes it. The
   // ring status seen here is the state right after that request, because no
   // later request can be accepted before it moves on.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= op_res;
      end
      if (out_free && s1_vld_ff) begin
         rsp_ok_ff           <= s1_res_ff.ok;
         rsp_read_data_ff    <= s1_res_ff.rd_ok ? byte_rd_ff : '0;
         rsp_head_length_ff  <= ring_stat.head_length;
         rsp_bytes_used_ff   <= ring_stat.bytes_used;
         rsp_bytes_free_ff   <= ring_stat.bytes_free;
         rsp_record_count_ff <= ring_stat.record_count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ok           = rsp_ok_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_head_length  = rsp_head_length_ff;
   assign rsp_bytes_used   = rsp_bytes_used_ff;
   assign rsp_bytes_free   = rsp_bytes_free_ff;
   assign rsp_record_count = rsp_record_count_ff;

   a_space_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (SUM_W'(rsp_bytes_used) + SUM_W'(rsp_bytes_free)) <= SUM_W'(CAP_CNT))
      else $error("used plus free bytes exceed the ring");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_record_count == '0 |->
         rsp_head_length == '0 && rsp_bytes_used == '0 && rsp_bytes_free == CAP_CNT)
      else $error("empty ring reports held bytes");

   a_read_needs_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_data != '0 |-> rsp_ok)
      else $error("read data on a rejected request");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("decoded request not handed to the response register");

endmodule
